// File: rtl/vra_pkg.sv
package vra_pkg;

  // Coordinate and angle formats.
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned ANGLE_W    = 32;
  localparam int unsigned ITERATIONS = 24;
  localparam int unsigned GUARD      = 8;

  // Working width of the rotator: guard bits, one bit for the negation of the
  // most negative input and two bits for the CORDIC growth of up to 2.33.
  localparam int unsigned WORK_W  = COORD_W + GUARD + 3;
  localparam int unsigned SHIFT_W = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;

  // The arctangent table has 32 entries.
  localparam int unsigned LUT_IDX_W = 5;

  // Gain compensation: 1/K in Q0.32, truncated.
  localparam logic [31:0] GAIN_Q32 = 32'd2608131496;
  localparam int unsigned HI_W     = (WORK_W > 32) ? WORK_W - 32 : 1;
  localparam int unsigned MAG_W    = 32 + HI_W;
  localparam int unsigned SUM_W    = HI_W + 33;
  localparam int unsigned RND_W    = SUM_W - GUARD;

  typedef struct packed {
    logic signed [COORD_W-1:0] vec_x;
    logic signed [COORD_W-1:0] vec_y;
    logic signed [ANGLE_W-1:0] turn_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] rot_x;
    logic signed [COORD_W-1:0] rot_y;
  } out_item_t;

  typedef struct packed {
    logic signed [WORK_W-1:0] x;
    logic signed [WORK_W-1:0] y;
    logic [ANGLE_W-1:0]       z;
  } stage_t;

  // atan(2^-i) in binary angle units, rounded to nearest.
  function automatic logic [ANGLE_W-1:0] atan_lut(input logic [LUT_IDX_W-1:0] idx);
    logic [ANGLE_W-1:0] val;
    case (idx)
      5'd0:    val = 32'd536870912;
      5'd1:    val = 32'd316933406;
      5'd2:    val = 32'd167458907;
      5'd3:    val = 32'd85004756;
      5'd4:    val = 32'd42667331;
      5'd5:    val = 32'd21354465;
      5'd6:    val = 32'd10679838;
      5'd7:    val = 32'd5340245;
      5'd8:    val = 32'd2670163;
      5'd9:    val = 32'd1335087;
      5'd10:   val = 32'd667544;
      5'd11:   val = 32'd333772;
      5'd12:   val = 32'd166886;
      5'd13:   val = 32'd83443;
      5'd14:   val = 32'd41722;
      5'd15:   val = 32'd20861;
      5'd16:   val = 32'd10430;
      5'd17:   val = 32'd5215;
      5'd18:   val = 32'd2608;
      5'd19:   val = 32'd1304;
      5'd20:   val = 32'd652;
      5'd21:   val = 32'd326;
      5'd22:   val = 32'd163;
      5'd23:   val = 32'd81;
      5'd24:   val = 32'd41;
      5'd25:   val = 32'd20;
      5'd26:   val = 32'd10;
      5'd27:   val = 32'd5;
      5'd28:   val = 32'd3;
      5'd29:   val = 32'd1;
      5'd30:   val = 32'd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// File: rtl/vra_prerot.sv
module vra_prerot (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  vra_pkg::in_item_t  item_i,
  output logic               valid_o,
  input  logic               ready_i,
  output vra_pkg::stage_t    stage_o
);
  import vra_pkg::*;

  logic                     valid_q;
  stage_t                   stage_q, stage_d;
  logic signed [WORK_W-1:0] x_ext, y_ext;
  logic                     flip;

  // Angles in the left half plane are turned by pi first, which leaves a
  // residual within plus or minus a quarter turn.
  always_comb begin
    x_ext = {{(WORK_W - COORD_W - GUARD){item_i.vec_x[COORD_W-1]}}, item_i.vec_x,
             {GUARD{1'b0}}};
    y_ext = {{(WORK_W - COORD_W - GUARD){item_i.vec_y[COORD_W-1]}}, item_i.vec_y,
             {GUARD{1'b0}}};
    flip = item_i.turn_angle[ANGLE_W-1] ^ item_i.turn_angle[ANGLE_W-2];
    stage_d.x = flip ? -x_ext : x_ext;
    stage_d.y = flip ? -y_ext : y_ext;
    stage_d.z = {item_i.turn_angle[ANGLE_W-1] ^ flip, item_i.turn_angle[ANGLE_W-2:0]};
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign stage_o = stage_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      stage_q <= stage_d;
    end
  end

endmodule

// File: rtl/vra_cell.sv
module vra_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [vra_pkg::SHIFT_W-1:0]  shift_i,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  vra_pkg::stage_t              stage_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output vra_pkg::stage_t              stage_o
);
  import vra_pkg::*;

  logic                     valid_q;
  stage_t                   stage_q, stage_d;
  logic signed [WORK_W-1:0] dx, dy;
  logic [ANGLE_W-1:0]       atan_c;
  logic                     dir_pos;

  // One micro-rotation; the shift amount is tied off per cell.
  always_comb begin
    dir_pos = !stage_i.z[ANGLE_W-1];
    dx      = stage_i.y >>> shift_i;
    dy      = stage_i.x >>> shift_i;
    atan_c  = atan_lut(LUT_IDX_W'(shift_i));
    if (dir_pos) begin
      stage_d.x = stage_i.x - dx;
      stage_d.y = stage_i.y + dy;
      stage_d.z = stage_i.z - atan_c;
    end else begin
      stage_d.x = stage_i.x + dx;
      stage_d.y = stage_i.y - dy;
      stage_d.z = stage_i.z + atan_c;
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign stage_o = stage_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      stage_q <= stage_d;
    end
  end

`ifndef ASSERT_OFF
  a_cell_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ready_i) |=> (valid_q && $stable(stage_q)))
    else $error("cell lost or changed a stalled item");
`endif

endmodule

// File: rtl/vra_gain.sv
module vra_gain (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  vra_pkg::stage_t     stage_i,
  output logic                valid_o,
  input  logic                ready_i,
  output vra_pkg::out_item_t  item_o
);
  import vra_pkg::*;

  // Stage 1: sign and magnitude.
  logic                  v1_q, r1;
  logic [1:0]            neg1_q, neg1_d;
  logic [MAG_W-1:0]      mag1_q [2];
  logic [MAG_W-1:0]      mag1_d [2];
  logic [WORK_W-1:0]     abs_w  [2];
  logic signed [WORK_W-1:0] lane_v [2];
  // Stage 2: partial products with the gain constant.
  logic                  v2_q, r2;
  logic [1:0]            neg2_q;
  logic [63:0]           lo_q [2];
  logic [HI_W+31:0]      hi_q [2];
  // Stage 3: round, restore sign, saturate.
  logic                  v3_q, r3;
  out_item_t             out_q, out_d;
  logic [SUM_W-1:0]      sum_w [2];
  logic [RND_W-1:0]      rnd_w [2];
  logic [COORD_W-1:0]    res_w [2];
  logic                  sat_pos, sat_neg;

  assign r3      = !v3_q || ready_i;
  assign r2      = !v2_q || r3;
  assign r1      = !v1_q || r2;
  assign ready_o = r1;
  assign valid_o = v3_q;
  assign item_o  = out_q;

  always_comb begin
    lane_v[0] = stage_i.x;
    lane_v[1] = stage_i.y;
    for (int k = 0; k < 2; k++) begin
      neg1_d[k] = lane_v[k][WORK_W-1];
      abs_w[k]  = neg1_d[k] ? WORK_W'(-lane_v[k]) : WORK_W'(lane_v[k]);
      mag1_d[k] = MAG_W'(abs_w[k]);
    end
  end

  always_comb begin
    sat_pos = 1'b0;
    sat_neg = 1'b0;
    for (int k = 0; k < 2; k++) begin
      sum_w[k] = SUM_W'(hi_q[k]) + SUM_W'(lo_q[k][63:32]) + SUM_W'(1 << (GUARD - 1));
      rnd_w[k] = sum_w[k][SUM_W-1:GUARD];
      sat_pos  = |rnd_w[k][RND_W-1:COORD_W-1];
      sat_neg  = (|rnd_w[k][RND_W-1:COORD_W]) ||
                 (rnd_w[k][COORD_W-1] && (|rnd_w[k][COORD_W-2:0]));
      if (neg2_q[k]) begin
        res_w[k] = sat_neg ? {1'b1, {(COORD_W-1){1'b0}}} : (~rnd_w[k][COORD_W-1:0] + 1'b1);
      end else begin
        res_w[k] = sat_pos ? {1'b0, {(COORD_W-1){1'b1}}} : rnd_w[k][COORD_W-1:0];
      end
    end
    out_d.rot_x = res_w[0];
    out_d.rot_y = res_w[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) begin
        v1_q <= valid_i;
      end
      if (r2) begin
        v2_q <= v1_q;
      end
      if (r3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && r1) begin
      neg1_q    <= neg1_d;
      mag1_q[0] <= mag1_d[0];
      mag1_q[1] <= mag1_d[1];
    end
    if (v1_q && r2) begin
      neg2_q <= neg1_q;
      for (int k = 0; k < 2; k++) begin
        lo_q[k] <= mag1_q[k][31:0] * GAIN_Q32;
        hi_q[k] <= mag1_q[k][MAG_W-1:32] * GAIN_Q32;
      end
    end
    if (v2_q && r3) begin
      out_q <= out_d;
    end
  end

`ifndef ASSERT_OFF
  a_gain_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !r3) |=> (v2_q && $stable(lo_q[0]) && $stable(hi_q[1])))
    else $error("gain stage changed its products while stalled");
`endif

endmodule

// File: rtl/vector_rotate_by_angle_core.sv
// Planar vector rotator built as a chain of CORDIC cells.
// The input channel (in_valid_i, in_ready_o, in_item_i) takes one item holding
// a Q16.16 vector and a signed binary angle, where the full 32-bit range spans
// minus pi to just under plus pi. The output channel (out_valid_o, out_ready_i,
// out_item_o) returns one item per input: the vector turned counter-clockwise,
// gain compensated, rounded and saturated to the coordinate range.
// From acceptance to out_valid_o an item passes one pre-rotation stage, one
// cell per CORDIC iteration and three stages for gain compensation
// (magnitude, multiply, round and saturate).
// Throughput is one item per cycle; every stage is a register with its own
// valid bit, so a new item is taken in each cycle that the chain moves.
// When the receiver stalls, items keep advancing into empty stages behind the
// waiting result, so in_ready_o only falls once the whole chain is full.
// in_ready_o is derived combinationally from out_ready_i along the chain.
// Reset clears every valid bit; the payload registers are not reset, and no
// item is lost or repeated across a stall.
module vector_rotate_by_angle_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vra_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vra_pkg::out_item_t  out_item_o
);
  import vra_pkg::*;

  // Handshake and data along the chain: index 0 is the pre-rotation stage,
  // index k+1 the output of cell k.
  logic   chain_valid [ITERATIONS+1];
  logic   chain_ready [ITERATIONS+1];
  stage_t chain_stage [ITERATIONS+1];

  // Quadrant correction so that the cells only see residual angles within
  // a quarter turn.
  vra_prerot u_prerot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item_i),
    .valid_o (chain_valid[0]),
    .ready_i (chain_ready[0]),
    .stage_o (chain_stage[0])
  );

  // One cell per iteration; each cell shifts by its own position in the row.
  for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
    vra_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (SHIFT_W'(k)),
      .valid_i (chain_valid[k]),
      .ready_o (chain_ready[k]),
      .stage_i (chain_stage[k]),
      .valid_o (chain_valid[k+1]),
      .ready_i (chain_ready[k+1]),
      .stage_o (chain_stage[k+1])
    );
  end

  // Removes the CORDIC gain and the guard bits, then saturates.
  vra_gain u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain_valid[ITERATIONS]),
    .ready_o (chain_ready[ITERATIONS]),
    .stage_i (chain_stage[ITERATIONS]),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .item_o  (out_item_o)
  );

`ifndef ASSERT_OFF
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled although no result is waiting");
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> chain_valid[0])
    else $error("accepted item did not reach the first stage");
`endif

endmodule
